### hw/rtl/mbe_pkg.sv
// ---------------------------------------------------------------------------
// mbe_pkg: shared types and constants for the escape-time pixel evaluator
// Fixed-point formats, queue entry type, register map and back-end states.
// ---------------------------------------------------------------------------
package mbe_pkg;

  // image and iteration limits
  localparam int IMG_WIDTH  = 1024;
  localparam int MAX_ITER   = 256;

  // field widths
  localparam int COORD_W    = 10;
  localparam int ADDR_W     = 20;
  localparam int ITER_OUT_W = 9;
  localparam int CNT_W      = $clog2(MAX_ITER + 1);

  // Q4.28 coordinates, Q8.56 products
  localparam int Q_W        = 32;
  localparam int Q_FRAC     = 28;
  localparam int PROD_W     = 2 * Q_W;
  localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << (2 * Q_FRAC);

  // c point product width: unsigned index times signed step
  localparam int CPROD_W    = COORD_W + 1 + Q_W;

  // queue between front and back end
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // register port
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  typedef enum logic [1:0] {
    REG_ORIGIN_RE = 2'd0,
    REG_ORIGIN_IM = 2'd1,
    REG_STEP_RE   = 2'd2,
    REG_STEP_IM   = 2'd3
  } cfg_reg_t;

  localparam logic signed [Q_W-1:0] ORIGIN_RE_RST = -32'sd536870912;
  localparam logic signed [Q_W-1:0] ORIGIN_IM_RST = -32'sd402653184;
  localparam logic signed [Q_W-1:0] STEP_RE_RST   = 32'sd786432;
  localparam logic signed [Q_W-1:0] STEP_IM_RST   = 32'sd786432;

  // one pixel job, as queued for the iteration engine
  typedef struct packed {
    logic signed [Q_W-1:0] c_re;
    logic signed [Q_W-1:0] c_im;
    logic [ADDR_W-1:0]     addr;
  } job_t;

  // queue fill state seen by both ends
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // iteration engine states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL
  } st_t;

  // saturate a wide signed value into Q4.28
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
    if (v[PROD_W-1:Q_W-1] == '0 || v[PROD_W-1:Q_W-1] == '1) begin
      return v[Q_W-1:0];
    end else if (v[PROD_W-1]) begin
      return {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

endpackage

### hw/rtl/mbe_front.sv
// ---------------------------------------------------------------------------
// mbe_front: register file and pixel set-up
// Holds the view registers, maps a pixel index to its point c and address,
// and pushes the job into the queue on each input transfer.
// ---------------------------------------------------------------------------
module mbe_front (
  input  logic                              clk,
  input  logic                              rst_n,
  // register port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mbe_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [mbe_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [mbe_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready,
  // pixel input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mbe_pkg::COORD_W-1:0]       in_column,
  input  logic [mbe_pkg::COORD_W-1:0]       in_row,
  // queue side
  input  mbe_pkg::qstat_t                   q_stat,
  output logic                              q_push,
  output mbe_pkg::job_t                     q_job
);

  logic signed [mbe_pkg::Q_W-1:0]     origin_re_r;
  logic signed [mbe_pkg::Q_W-1:0]     origin_im_r;
  logic signed [mbe_pkg::Q_W-1:0]     step_re_r;
  logic signed [mbe_pkg::Q_W-1:0]     step_im_r;
  logic                               wr_en;
  mbe_pkg::cfg_reg_t                  reg_sel;
  logic signed [mbe_pkg::CPROD_W-1:0] re_prod;
  logic signed [mbe_pkg::CPROD_W-1:0] im_prod;
  logic signed [mbe_pkg::PROD_W-1:0]  re_sum;
  logic signed [mbe_pkg::PROD_W-1:0]  im_sum;

  // register decode
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = mbe_pkg::cfg_reg_t'(cfg_paddr[3:2]);

  // view registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_re_r <= mbe_pkg::ORIGIN_RE_RST;
      origin_im_r <= mbe_pkg::ORIGIN_IM_RST;
      step_re_r   <= mbe_pkg::STEP_RE_RST;
      step_im_r   <= mbe_pkg::STEP_IM_RST;
    end else if (wr_en) begin
      case (reg_sel)
        mbe_pkg::REG_ORIGIN_RE: origin_re_r <= signed'(cfg_pwdata);
        mbe_pkg::REG_ORIGIN_IM: origin_im_r <= signed'(cfg_pwdata);
        mbe_pkg::REG_STEP_RE:   step_re_r   <= signed'(cfg_pwdata);
        mbe_pkg::REG_STEP_IM:   step_im_r   <= signed'(cfg_pwdata);
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      mbe_pkg::REG_ORIGIN_RE: cfg_prdata = origin_re_r;
      mbe_pkg::REG_ORIGIN_IM: cfg_prdata = origin_im_r;
      mbe_pkg::REG_STEP_RE:   cfg_prdata = step_re_r;
      mbe_pkg::REG_STEP_IM:   cfg_prdata = step_im_r;
      default:                cfg_prdata = '0;
    endcase
  end

  // point c = origin + index * step, exact then saturated
  assign re_prod = $signed({1'b0, in_column}) * step_re_r;
  assign im_prod = $signed({1'b0, in_row}) * step_im_r;
  assign re_sum  = mbe_pkg::PROD_W'(re_prod) + mbe_pkg::PROD_W'(origin_re_r);
  assign im_sum  = mbe_pkg::PROD_W'(im_prod) + mbe_pkg::PROD_W'(origin_im_r);

  // job out to the queue
  assign in_stall   = q_stat.full;
  assign q_push     = in_valid && !q_stat.full;
  assign q_job.c_re = mbe_pkg::sat_q(re_sum);
  assign q_job.c_im = mbe_pkg::sat_q(im_sum);
  assign q_job.addr = mbe_pkg::ADDR_W'(mbe_pkg::ADDR_W'(in_row) *
                      mbe_pkg::ADDR_W'(mbe_pkg::IMG_WIDTH) +
                      mbe_pkg::ADDR_W'(in_column));

endmodule

### hw/rtl/mbe_queue.sv
// ---------------------------------------------------------------------------
// mbe_queue: job queue
// Small register queue that lets the set-up stage run ahead of the engine.
// ---------------------------------------------------------------------------
module mbe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbe_pkg::job_t   push_job,
  input  logic            pop,
  output mbe_pkg::job_t   head_job,
  output mbe_pkg::qstat_t stat
);

  mbe_pkg::job_t               ent_r [mbe_pkg::QDEPTH];
  logic [mbe_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [mbe_pkg::QPTR_W-1:0]  wr_ptr_nxt;
  logic [mbe_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [mbe_pkg::QPTR_W-1:0]  rd_ptr_nxt;
  logic [mbe_pkg::QCNT_W-1:0]  cnt_r;
  logic [mbe_pkg::QCNT_W-1:0]  cnt_nxt;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mbe_pkg::QPTR_W'(mbe_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mbe_pkg::QPTR_W'(mbe_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_job   = ent_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == mbe_pkg::QCNT_W'(mbe_pkg::QDEPTH));

endmodule

### hw/rtl/mbe_back.sv
// ---------------------------------------------------------------------------
// mbe_back: iteration engine
// Runs z = z^2 + c for one queued pixel, a multiply and an evaluate state
// per iteration: products are registered, then escape test and z update.
// ---------------------------------------------------------------------------
module mbe_back (
  input  logic                              clk,
  input  logic                              rst_n,
  // queue side
  input  mbe_pkg::qstat_t                   q_stat,
  input  mbe_pkg::job_t                     q_job,
  output logic                              q_pop,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mbe_pkg::ITER_OUT_W-1:0]    out_iteration_count,
  output logic [mbe_pkg::ADDR_W-1:0]        out_pixel_address
);

  mbe_pkg::st_t                      state_r;
  mbe_pkg::st_t                      state_nxt;
  logic signed [mbe_pkg::Q_W-1:0]    zre_r;
  logic signed [mbe_pkg::Q_W-1:0]    zim_r;
  logic signed [mbe_pkg::Q_W-1:0]    cre_r;
  logic signed [mbe_pkg::Q_W-1:0]    cim_r;
  logic [mbe_pkg::ADDR_W-1:0]        addr_r;
  logic [mbe_pkg::CNT_W-1:0]         cnt_r;
  logic signed [mbe_pkg::PROD_W-1:0] rr_r;
  logic signed [mbe_pkg::PROD_W-1:0] ii_r;
  logic signed [mbe_pkg::PROD_W-1:0] ri_r;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [mbe_pkg::ITER_OUT_W-1:0]    out_cnt_r;
  logic [mbe_pkg::ADDR_W-1:0]        out_addr_r;

  logic [mbe_pkg::PROD_W-1:0]        mag;
  logic signed [mbe_pkg::PROD_W-1:0] diff;
  logic signed [mbe_pkg::PROD_W-1:0] nre_sum;
  logic signed [mbe_pkg::PROD_W-1:0] nim_sum;
  logic                              go_on;
  logic                              out_free;
  logic                              load;
  logic                              step;
  logic                              finish;

  // escape test and next z
  assign mag     = $unsigned(rr_r) + $unsigned(ii_r);
  assign go_on   = (cnt_r < mbe_pkg::CNT_W'(mbe_pkg::MAX_ITER)) && (mag < mbe_pkg::ESC_LIMIT);
  assign diff    = rr_r - ii_r;
  assign nre_sum = (diff >>> mbe_pkg::Q_FRAC) + mbe_pkg::PROD_W'(cre_r);
  assign nim_sum = (ri_r >>> (mbe_pkg::Q_FRAC - 1)) + mbe_pkg::PROD_W'(cim_r);
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbe_pkg::ST_IDLE: begin
        if (!q_stat.empty) state_nxt = mbe_pkg::ST_MUL;
      end
      mbe_pkg::ST_MUL: begin
        state_nxt = mbe_pkg::ST_EVAL;
      end
      mbe_pkg::ST_EVAL: begin
        if (go_on) begin
          state_nxt = mbe_pkg::ST_MUL;
        end else if (out_free) begin
          state_nxt = mbe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mbe_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    load   = 1'b0;
    step   = 1'b0;
    finish = 1'b0;
    case (state_r)
      mbe_pkg::ST_IDLE: load   = !q_stat.empty;
      mbe_pkg::ST_EVAL: begin
        step   = go_on;
        finish = !go_on && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // job registers and z update
  always_ff @(posedge clk) begin
    if (load) begin
      cre_r  <= q_job.c_re;
      cim_r  <= q_job.c_im;
      addr_r <= q_job.addr;
      zre_r  <= '0;
      zim_r  <= '0;
      cnt_r  <= '0;
    end else if (step) begin
      zre_r  <= mbe_pkg::sat_q(nre_sum);
      zim_r  <= mbe_pkg::sat_q(nim_sum);
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  // product registers
  always_ff @(posedge clk) begin
    if (state_r == mbe_pkg::ST_MUL) begin
      rr_r <= zre_r * zre_r;
      ii_r <= zim_r * zim_r;
      ri_r <= zre_r * zim_r;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_cnt_r  <= mbe_pkg::ITER_OUT_W'(cnt_r);
      out_addr_r <= addr_r;
    end
  end

  assign q_pop               = load;
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_cnt_r;
  assign out_pixel_address   = out_addr_r;

endmodule

### hw/rtl/mandelbrot_escape_time_pixel.sv
// ---------------------------------------------------------------------------
// mandelbrot_escape_time_pixel: escape-time evaluator for one pixel per job
// Maps a pixel index to a point c and counts z = z^2 + c iterations.
// ---------------------------------------------------------------------------
// Usage
//   in_*  : pixel column and row; a transfer happens when in_valid is high
//           and in_stall is low. The job is set up and queued in that cycle.
//   out_* : iteration count (1..256, 256 = never escaped) and linear pixel
//           address, held in an output register until taken.
//   cfg_* : register port for origin_re, origin_im, step_re, step_im
//           (Q4.28, byte addresses 0, 4, 8, 12); write only while idle.
// Engine sequence
//   A pixel that runs N iterations occupies the engine for a load state,
//   then a multiply state and an evaluate state for each of the N
//   iterations and for the final escape test.
//   The iteration loop through the complex-square multipliers sets the
//   rate; queue wait and output stalls add to the time to out_valid.
//   A two-entry queue lets new pixels be taken while the engine is busy.
// Reset and stall
//   Synchronous reset empties the queue, drops out_valid and loads the
//   default view. A stalled result holds; the engine waits with its finished
//   pixel and the queue fills, after which in_stall rises.
// ---------------------------------------------------------------------------
module mandelbrot_escape_time_pixel (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mbe_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [mbe_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [mbe_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mbe_pkg::COORD_W-1:0]       in_column,
  input  logic [mbe_pkg::COORD_W-1:0]       in_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mbe_pkg::ITER_OUT_W-1:0]    out_iteration_count,
  output logic [mbe_pkg::ADDR_W-1:0]        out_pixel_address
);

  mbe_pkg::qstat_t q_stat;
  mbe_pkg::job_t   push_job;
  mbe_pkg::job_t   head_job;
  logic            q_push;
  logic            q_pop;

  // set-up and registers
  mbe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_column   (in_column),
    .in_row      (in_row),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  // job queue
  mbe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  // iteration engine
  mbe_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .q_job               (head_job),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_iteration_count (out_iteration_count),
    .out_pixel_address   (out_pixel_address)
  );

  // engine never reads an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // a full queue stays full until the engine pops
  a_push_pop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !q_pop) |=> q_stat.full)
    else $error("queue lost an entry while full");

  // every result has done at least one iteration and no more than the limit
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_iteration_count != '0 &&
                   out_iteration_count <= mbe_pkg::ITER_OUT_W'(mbe_pkg::MAX_ITER)))
    else $error("iteration count out of range");

endmodule

### tb/mandelbrot_escape_time_pixel_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_tb: self-checking bench for the pixel evaluator
// Pixels go in through a queue-fed driver; each accepted transfer is scored
// against an in-bench fixed-point escape-time calculation and compared, field
// by field and in order, with the results taken by the monitor. The view
// registers are written between phases, over saturating and degenerate views
// as well as random views around the set.
// ---------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_tb;

  import mbe_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 2000;
  localparam int DRAIN_CYCLES   = 600;
  localparam int VIEW_ITEMS     = 205;
  localparam longint unsigned ESCAPE_BOUND = 64'h0400_0000_0000_0000;
  localparam longint Q_MAX      = 64'sd2147483647;
  localparam longint Q_MIN      = -64'sd2147483648;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [ITER_OUT_W-1:0] iterations;
    logic [ADDR_W-1:0]     address;
  } escape_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COORD_W-1:0]    in_column = '0;
  logic [COORD_W-1:0]    in_row = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ITER_OUT_W-1:0] out_iteration_count;
  logic [ADDR_W-1:0]     out_pixel_address;

  // bench copy of the view registers
  logic signed [Q_W-1:0] view_reg [4];

  pixel_t  pixel_backlog[$];
  escape_t pending_escapes[$];

  int  error_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  bit  idle_enabled = 1'b0;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;

  mandelbrot_escape_time_pixel dut (.*);

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp_q428(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // escape-time count and linear address for one pixel under the current view
  function automatic escape_t escape_of_pixel(input logic [COORD_W-1:0] column,
                                              input logic [COORD_W-1:0] row);
    longint          c_re, c_im, z_re, z_im, next_re, lin_addr;
    longint unsigned abs_re, abs_im;
    int unsigned     iters;
    escape_t         res;
    c_re = clamp_q428(longint'(view_reg[REG_ORIGIN_RE]) +
                      longint'(column) * longint'(view_reg[REG_STEP_RE]));
    c_im = clamp_q428(longint'(view_reg[REG_ORIGIN_IM]) +
                      longint'(row) * longint'(view_reg[REG_STEP_IM]));
    z_re = 0;
    z_im = 0;
    iters = 0;
    while (iters < MAX_ITER) begin
      abs_re = (z_re < 0) ? -z_re : z_re;
      abs_im = (z_im < 0) ? -z_im : z_im;
      if (abs_re * abs_re + abs_im * abs_im >= ESCAPE_BOUND) break;
      // floor shifts: arithmetic right shift of the exact Q8.56 terms
      next_re = clamp_q428(((z_re * z_re - z_im * z_im) >>> Q_FRAC) + c_re);
      z_im = clamp_q428(((z_re * z_im) >>> (Q_FRAC - 1)) + c_im);
      z_re = next_re;
      iters++;
    end
    lin_addr = longint'(row) * IMG_WIDTH + longint'(column);
    res.iterations = iters[ITER_OUT_W-1:0];
    res.address = lin_addr[ADDR_W-1:0];
    return res;
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  // pixel driver: predicts on each accepted transfer, then offers the next pixel
  always @(posedge clk) begin : drive_pixels
    pixel_t next_pixel;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_escapes.push_back(escape_of_pixel(in_column, in_row));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (pixel_backlog.size() > 0) begin
          next_pixel = pixel_backlog.pop_front();
          in_valid <= 1'b1;
          in_column <= next_pixel.column;
          in_row <= next_pixel.row;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : take_results
    escape_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_escapes.size() == 0) begin
          note_error($sformatf("unexpected result: iterations %0d address %0d",
                               out_iteration_count, out_pixel_address));
        end else begin
          want = pending_escapes.pop_front();
          if (out_iteration_count !== want.iterations ||
              out_pixel_address !== want.address) begin
            note_error($sformatf({"result mismatch: iterations exp %0d got %0d, ",
                                  "address exp %0d got %0d"},
                                 want.iterations, out_iteration_count,
                                 want.address, out_pixel_address));
          end
        end
      end
      // long hold-off once, else short random bursts
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (long_hold_req && !long_hold_done) begin
        hold_left <= LONG_HOLD;
        long_hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_view_reg(input cfg_reg_t which, input logic [Q_W-1:0] value);
    logic [CFG_AW-1:0] byte_addr;
    byte_addr = {which, 2'b00};
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= byte_addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    view_reg[which] = value;
  endtask

  task automatic write_view(input logic [Q_W-1:0] o_re, input logic [Q_W-1:0] o_im,
                            input logic [Q_W-1:0] s_re, input logic [Q_W-1:0] s_im);
    write_view_reg(REG_ORIGIN_RE, o_re);
    write_view_reg(REG_ORIGIN_IM, o_im);
    write_view_reg(REG_STEP_RE, s_re);
    write_view_reg(REG_STEP_IM, s_im);
  endtask

  task automatic add_pixel(input int column, input int row);
    pixel_backlog.push_back('{column: column[COORD_W-1:0], row: row[COORD_W-1:0]});
  endtask

  task automatic add_random_pixels(input int count);
    repeat (count) add_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  // sender stays quiet until every pixel sent has come back
  task automatic wait_all_results();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || in_valid || pending_escapes.size() != 0);
  endtask

  // stimulus sequence
  initial begin
    int o_re, o_im, s_re, s_im;
    view_reg[REG_ORIGIN_RE] = ORIGIN_RE_RST;
    view_reg[REG_ORIGIN_IM] = ORIGIN_IM_RST;
    view_reg[REG_STEP_RE] = STEP_RE_RST;
    view_reg[REG_STEP_IM] = STEP_IM_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset view: corners, c = -2 on the escape boundary, points inside the set
    add_pixel(0, 0);
    add_pixel(0, 512);
    add_pixel(512, 512);
    add_pixel(1023, 1023);
    add_pixel(0, 1023);
    add_pixel(1023, 0);
    add_pixel('h2AA, 'h155);
    add_pixel('h155, 'h2AA);
    add_pixel(683, 512);
    wait_all_results();

    // saturating views, c driven past both ends of the format
    write_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_pixel(0, 0);
    add_pixel(1, 1);
    add_pixel(1023, 1023);
    add_pixel(1023, 0);
    wait_all_results();
    write_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_pixel(0, 0);
    add_pixel(1023, 1023);
    add_pixel(512, 1);
    wait_all_results();

    // degenerate views: c at or next to zero, never escapes
    write_view(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_pixel(1023, 1023);
    add_pixel(0, 0);
    wait_all_results();
    write_view_reg(REG_STEP_RE, 32'h0000_0000);
    write_view_reg(REG_STEP_IM, 32'h0000_0000);
    add_pixel(5, 7);
    wait_all_results();

    // random views around the set
    idle_enabled = 1'b1;
    for (int view = 0; view < 6; view++) begin
      if (view == 0) begin
        write_view(ORIGIN_RE_RST, ORIGIN_IM_RST, STEP_RE_RST, STEP_IM_RST);
      end else begin
        o_re = -603979776 + int'($urandom_range(0, 671088640));
        o_im = -402653184 + int'($urandom_range(0, 268435456));
        s_re = int'($urandom_range(65536, 1048576));
        s_im = int'($urandom_range(65536, 1048576));
        if ($urandom_range(0, 3) == 0) s_re = -s_re;
        write_view(o_re, o_im, s_re, s_im);
      end
      // last part of the run without idling
      if (view == 5) idle_enabled = 1'b0;
      if (view == 1) long_hold_req = 1'b1;
      if (view == 2) begin
        add_random_pixels(VIEW_ITEMS / 2);
        wait_all_results();
        add_random_pixels(VIEW_ITEMS - VIEW_ITEMS / 2);
      end else begin
        add_random_pixels(VIEW_ITEMS);
      end
      wait_all_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_escapes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_front.sv
hw/rtl/mbe_queue.sv
hw/rtl/mbe_back.sv
hw/rtl/mandelbrot_escape_time_pixel.sv
tb/mandelbrot_escape_time_pixel_tb.sv
